FILE: rtl/mced_pkg.sv
package mced_pkg;

    // ascii codes used by the codec
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_ERR   = 8'h00;

    localparam int NUM_CODES  = 36;
    localparam int NUM_ALPHA  = 26;
    localparam int MAX_SYM    = 5;
    localparam int SPACE_RUN  = 7;

    // command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // positions within one command: prefix, body symbols 1..7, suffix
    localparam logic [3:0] POS_PRE  = 4'd0;
    localparam logic [3:0] POS_BODY = 4'd1;
    localparam logic [3:0] POS_POST = 4'd8;

    // symbol i of a code in bit i, dash = 1; A-Z then 0-9
    localparam logic [4:0] CODE_BITS [NUM_CODES] = '{
        5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100, 5'b00011,
        5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010, 5'b00011, 5'b00001,
        5'b00111, 5'b00110, 5'b01011, 5'b00010, 5'b00000, 5'b00001, 5'b00100,
        5'b01000, 5'b00110, 5'b01001, 5'b01101, 5'b00011,
        5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000, 5'b00000, 5'b00001,
        5'b00011, 5'b00111, 5'b01111
    };

    localparam logic [2:0] CODE_LEN [NUM_CODES] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
        3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
        3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // one queued command: optional prefix byte, body of up to seven bytes,
    // optional suffix byte
    typedef struct packed {
        logic       has_pre;
        logic [7:0] pre_byte;
        logic       pre_err;
        logic [2:0] body_len;
        logic       body_morse;
        logic [4:0] body_bits;
        logic [7:0] body_byte;
        logic       body_err;
        logic       has_post;
        logic [7:0] post_byte;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_qstat;

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= CH_A) && (c <= CH_Z)) || ((c >= CH_ZERO) && (c <= CH_NINE));
    endfunction

    function automatic logic [5:0] char_idx(input logic [7:0] c);
        logic [7:0] t;
        if ((c >= CH_A) && (c <= CH_Z)) begin
            t = c - CH_A;
        end else begin
            t = c - CH_ZERO + 8'(NUM_ALPHA);
        end
        return t[5:0];
    endfunction

    function automatic logic [7:0] index_char(input logic [5:0] i);
        logic [7:0] t;
        if (i < 6'(NUM_ALPHA)) begin
            t = CH_A + {2'b00, i};
        end else begin
            t = CH_ZERO + {2'b00, i} - 8'(NUM_ALPHA);
        end
        return t;
    endfunction

    // zero when the pattern has no mapping
    function automatic logic [7:0] decode_token(input logic [4:0] bits, input logic [2:0] len);
        logic [7:0] res;
        res = CH_ERR;
        for (int i = 0; i < NUM_CODES; i++) begin
            if ((CODE_LEN[i] == len) && (CODE_BITS[i] == bits)) begin
                res = index_char(6'(i));
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/mced_front.sv
module mced_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [7:0]           i_in_byte,
    output logic                 o_push,
    output mced_pkg::t_cmd       o_cmd
);

    logic       r_encode_mode, n_encode_mode;
    logic       r_prev_nonblank, n_prev_nonblank;
    logic [4:0] r_tok_bits, n_tok_bits;
    logic [2:0] r_tok_len, n_tok_len;
    logic       r_tok_bad, n_tok_bad;
    logic [2:0] r_blank_run, n_blank_run;

    mced_pkg::t_cmd cmd;
    logic [5:0]     idx;
    logic [7:0]     dec;

    assign idx = mced_pkg::char_idx(i_in_byte);
    assign dec = r_tok_bad ? mced_pkg::CH_ERR : mced_pkg::decode_token(r_tok_bits, r_tok_len);

    always_comb begin
        n_encode_mode   = i_cfg_we ? i_cfg_wdata : r_encode_mode;
        n_prev_nonblank = r_prev_nonblank;
        n_tok_bits      = r_tok_bits;
        n_tok_len       = r_tok_len;
        n_tok_bad       = r_tok_bad;
        n_blank_run     = r_blank_run;

        cmd            = '0;
        cmd.pre_byte   = mced_pkg::CH_SPACE;
        cmd.body_byte  = mced_pkg::CH_SPACE;

        if (r_encode_mode) begin
            if (i_in_byte == mced_pkg::CH_NL) begin
                cmd.has_pre     = 1'b1;
                cmd.pre_byte    = mced_pkg::CH_NL;
                n_prev_nonblank = 1'b0;
            end else if (i_in_byte == mced_pkg::CH_SPACE) begin
                cmd.body_len    = 3'(mced_pkg::SPACE_RUN);
                n_prev_nonblank = 1'b0;
            end else begin
                // separating blank between adjacent characters
                cmd.has_pre     = r_prev_nonblank;
                n_prev_nonblank = 1'b1;
                if (mced_pkg::is_alnum(i_in_byte)) begin
                    cmd.body_len   = mced_pkg::CODE_LEN[idx];
                    cmd.body_bits  = mced_pkg::CODE_BITS[idx];
                    cmd.body_morse = 1'b1;
                end else begin
                    cmd.body_len  = 3'd1;
                    cmd.body_byte = mced_pkg::CH_ERR;
                    cmd.body_err  = 1'b1;
                end
            end
        end else begin
            if ((i_in_byte == mced_pkg::CH_DOT) || (i_in_byte == mced_pkg::CH_DASH)) begin
                n_blank_run = '0;
                if (r_tok_len < 3'(mced_pkg::MAX_SYM)) begin
                    if (i_in_byte == mced_pkg::CH_DASH) begin
                        n_tok_bits[r_tok_len] = 1'b1;
                    end
                    n_tok_len = r_tok_len + 3'd1;
                end else begin
                    n_tok_len = 3'(mced_pkg::MAX_SYM + 1);
                end
            end else if ((i_in_byte == mced_pkg::CH_SPACE) || (i_in_byte == mced_pkg::CH_NL)) begin
                // pending token closes first
                if ((r_tok_len != 3'd0) || r_tok_bad) begin
                    cmd.has_pre  = 1'b1;
                    cmd.pre_byte = dec;
                    cmd.pre_err  = (dec == mced_pkg::CH_ERR);
                end
                n_tok_bits = '0;
                n_tok_len  = '0;
                n_tok_bad  = 1'b0;
                if (i_in_byte == mced_pkg::CH_NL) begin
                    cmd.has_post    = 1'b1;
                    cmd.post_byte   = mced_pkg::CH_NL;
                    n_blank_run     = '0;
                    n_prev_nonblank = 1'b0;
                end else if (r_blank_run == 3'(mced_pkg::SPACE_RUN - 1)) begin
                    cmd.has_post  = 1'b1;
                    cmd.post_byte = mced_pkg::CH_SPACE;
                    n_blank_run   = '0;
                end else begin
                    n_blank_run = r_blank_run + 3'd1;
                end
            end else begin
                n_tok_bad   = 1'b1;
                n_blank_run = '0;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && (cmd.has_pre || cmd.has_post || (cmd.body_len != 3'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encode_mode   <= 1'b1;
            r_prev_nonblank <= 1'b0;
            r_tok_bits      <= '0;
            r_tok_len       <= '0;
            r_tok_bad       <= 1'b0;
            r_blank_run     <= '0;
        end else begin
            r_encode_mode <= n_encode_mode;
            if (i_accept) begin
                r_prev_nonblank <= n_prev_nonblank;
                r_tok_bits      <= n_tok_bits;
                r_tok_len       <= n_tok_len;
                r_tok_bad       <= n_tok_bad;
                r_blank_run     <= n_blank_run;
            end
        end
    end

endmodule

FILE: rtl/mced_queue.sv
module mced_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mced_pkg::t_cmd     i_cmd,
    input  logic               i_pop,
    output mced_pkg::t_head    o_head,
    output mced_pkg::t_qstat   o_stat
);

    mced_pkg::t_cmd r_mem [mced_pkg::QDEPTH];

    logic [mced_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [mced_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [mced_pkg::QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;

endmodule

FILE: rtl/mced_back.sv
module mced_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mced_pkg::t_head   i_head,
    output logic              o_qpop,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_is_error,
    output logic              o_last
);

    logic       r_started;
    logic [3:0] r_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_err;
    logic       r_out_last;

    mced_pkg::t_cmd cmd;
    logic [3:0]     init_pos, cur, nxt, boff;
    logic [2:0]     bidx;
    logic           cur_last, load;
    logic [7:0]     cur_byte;
    logic           cur_err;

    assign cmd = i_head.cmd;

    always_comb begin
        if (cmd.has_pre) begin
            init_pos = mced_pkg::POS_PRE;
        end else if (cmd.body_len != 3'd0) begin
            init_pos = mced_pkg::POS_BODY;
        end else begin
            init_pos = mced_pkg::POS_POST;
        end
        cur  = r_started ? r_pos : init_pos;
        boff = cur - mced_pkg::POS_BODY;
        bidx = boff[2:0];

        nxt      = mced_pkg::POS_POST;
        cur_last = 1'b1;
        if (cur == mced_pkg::POS_PRE) begin
            cur_byte = cmd.pre_byte;
            cur_err  = cmd.pre_err;
            if (cmd.body_len != 3'd0) begin
                nxt      = mced_pkg::POS_BODY;
                cur_last = 1'b0;
            end else begin
                cur_last = !cmd.has_post;
            end
        end else if (cur == mced_pkg::POS_POST) begin
            cur_byte = cmd.post_byte;
            cur_err  = 1'b0;
        end else begin
            if (cmd.body_morse) begin
                cur_byte = cmd.body_bits[bidx] ? mced_pkg::CH_DASH : mced_pkg::CH_DOT;
            end else begin
                cur_byte = cmd.body_byte;
            end
            cur_err = cmd.body_err;
            if (cur < {1'b0, cmd.body_len}) begin
                nxt      = cur + 4'd1;
                cur_last = 1'b0;
            end else begin
                cur_last = !cmd.has_post;
            end
        end
    end

    // output register refills while its byte is being taken
    assign load   = i_head.valid && (!r_out_valid || i_pop);
    assign o_qpop = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_err  <= cur_err;
            r_out_last <= cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_pos       <= mced_pkg::POS_PRE;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_started   <= !cur_last;
                r_pos       <= nxt;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_is_error = r_out_err;
    assign o_last     = r_out_last;

endmodule

FILE: rtl/morse_code_encoder_decoder_top.sv
// a byte's command passes through the queue into the back end's output register
// throughput: one result per cycle from the back end while the receiver pops; a byte
//   gives one to seven results, a byte with no result takes no back end time
// the four-entry command queue lets up to four commands wait ahead of the back end
// reset: i_rst_n low at a clock edge (synchronous) empties the queue and output register,
//   clears all line state and sets encode mode; no clearing pass is needed
module morse_code_encoder_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: encode_mode
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // input channel
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    // result channel
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_is_error,
    output logic       o_last
);

    logic               accept;
    logic               q_push;
    logic               q_pop;
    logic               out_valid;
    mced_pkg::t_cmd     q_cmd;
    mced_pkg::t_head    q_head;
    mced_pkg::t_qstat   q_stat;

    // input transfer; full only reflects the command queue
    assign full   = (q_stat.count == mced_pkg::QCNT_W'(mced_pkg::QDEPTH));
    assign accept = push && !full;

    // front end: mode register, line and token state, builds one command per byte
    mced_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .o_push      (q_push),
        .o_cmd       (q_cmd)
    );

    // short command queue decouples front from back
    mced_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // back end: walks a command into the output register, a byte per cycle unless stalled
    mced_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .o_qpop     (q_pop),
        .i_pop      (pop),
        .o_valid    (out_valid),
        .o_out_byte (o_out_byte),
        .o_is_error (o_is_error),
        .o_last     (o_last)
    );

    assign empty = !out_valid;

`ifndef ASSERT_OFF
    // a result that is not the last of its byte is followed at once
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last) |=> !empty)
        else $error("result sequence broken before last");

    // command queue never holds more than its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= mced_pkg::QCNT_W'(mced_pkg::QDEPTH))
        else $error("command queue overflow");

    // back end only retires a command the queue actually holds
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_stat.count != '0))
        else $error("command retired from empty queue");
`endif

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 6;       // idle cycles before a mode write
    localparam int TAIL_CYCLES   = 10;      // quiet time after the last result

    // what the driver does with one queued entry
    typedef enum logic [1:0] {ACT_BYTE, ACT_MODE, ACT_SETTLE} t_act;

    typedef struct {
        t_act       act;
        logic [7:0] data;
        logic       calm;       // no idling on either side once this is issued
    } t_stim;

    typedef struct {
        logic [7:0] out_byte;
        logic       is_error;
        logic       last;
    } t_out;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b1;
    logic       push        = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       pop         = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_is_error;
    logic       o_last;

    t_stim in_bytes_q [$];
    t_out  want_out [$];
    int    queued_bytes = 0;
    int    error_count  = 0;
    int    gap_cnt      = 0;
    int    settle_cnt   = 0;
    int    hold_cnt     = 0;
    logic  calm_run     = 1'b0;

    // predicted codec state
    logic       enc_mode;
    logic       prev_nb;
    logic [4:0] tok_bits;
    logic [2:0] tok_len;
    logic       tok_bad;
    logic [2:0] blank_cnt;

    morse_code_encoder_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_is_error  (o_is_error),
        .o_last      (o_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // dot/dash text of each code, A-Z then 0-9
    function automatic string morse_of(input int idx);
        case (idx)
            0:  return ".-";     1:  return "-...";   2:  return "-.-.";   3:  return "-..";
            4:  return ".";      5:  return "..-.";   6:  return "--.";    7:  return "....";
            8:  return "..";     9:  return ".---";   10: return "-.-";    11: return ".-..";
            12: return "--";     13: return "-.";     14: return "---";    15: return ".--.";
            16: return "--.-";   17: return ".-.";    18: return "...";    19: return "-";
            20: return "..-";    21: return "...-";   22: return ".--";    23: return "-..-";
            24: return "-.--";   25: return "--..";
            26: return "-----";  27: return ".----";  28: return "..---";  29: return "...--";
            30: return "....-";  31: return ".....";  32: return "-....";  33: return "--...";
            34: return "---..";  35: return "----.";
            default: return "";
        endcase
    endfunction

    function automatic logic [7:0] glyph_of(input int idx);
        return (idx < 26) ? 8'(mced_pkg::CH_A + idx) : 8'(mced_pkg::CH_ZERO + idx - 26);
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic err);
        t_out r;
        r.out_byte = b;
        r.is_error = err;
        r.last     = 1'b0;
        want_out.push_back(r);
    endfunction

    // expected results of one accepted byte, state updated in place
    function automatic void translate_byte(input logic [7:0] c);
        int         base_cnt;
        int         idx;
        int         slen;
        logic [4:0] pbits;
        logic [7:0] d;
        string      s;
        base_cnt = want_out.size();
        if (enc_mode) begin
            if (c == mced_pkg::CH_NL) begin
                add_result(mced_pkg::CH_NL, 1'b0);
                prev_nb = 1'b0;
            end else if (c == mced_pkg::CH_SPACE) begin
                repeat (mced_pkg::SPACE_RUN) add_result(mced_pkg::CH_SPACE, 1'b0);
                prev_nb = 1'b0;
            end else begin
                if (c >= mced_pkg::CH_A && c <= mced_pkg::CH_Z) begin
                    idx = int'(c - mced_pkg::CH_A);
                end else if (c >= mced_pkg::CH_ZERO && c <= mced_pkg::CH_NINE) begin
                    idx = 26 + int'(c - mced_pkg::CH_ZERO);
                end else begin
                    idx = -1;
                end
                // separating blank between adjacent non-blank characters
                if (prev_nb) add_result(mced_pkg::CH_SPACE, 1'b0);
                prev_nb = 1'b1;
                if (idx < 0) begin
                    add_result(mced_pkg::CH_ERR, 1'b1);
                end else begin
                    s = morse_of(idx);
                    for (int k = 0; k < s.len(); k++) add_result(s[k], 1'b0);
                end
            end
        end else begin
            if (c == mced_pkg::CH_DOT || c == mced_pkg::CH_DASH) begin
                blank_cnt = '0;
                if (tok_len < 3'(mced_pkg::MAX_SYM)) begin
                    if (c == mced_pkg::CH_DASH) tok_bits[tok_len] = 1'b1;
                    tok_len = tok_len + 3'd1;
                end else begin
                    tok_len = 3'd6;     // overflow marker
                end
            end else if (c == mced_pkg::CH_SPACE || c == mced_pkg::CH_NL) begin
                // a closed token always gives one result, good or bad
                if (tok_len != 0 || tok_bad) begin
                    d = mced_pkg::CH_ERR;
                    if (!tok_bad && tok_len <= 3'(mced_pkg::MAX_SYM)) begin
                        for (int i = 0; i < 36; i++) begin
                            s     = morse_of(i);
                            slen  = s.len();
                            pbits = '0;
                            for (int k = 0; k < slen; k++) begin
                                if (s[k] == mced_pkg::CH_DASH) pbits[k] = 1'b1;
                            end
                            if (slen == int'(tok_len) && pbits == tok_bits) d = glyph_of(i);
                        end
                    end
                    add_result(d, d == mced_pkg::CH_ERR);
                    tok_bits = '0;
                    tok_len  = '0;
                    tok_bad  = 1'b0;
                end
                if (c == mced_pkg::CH_NL) begin
                    add_result(mced_pkg::CH_NL, 1'b0);
                    blank_cnt = '0;
                    prev_nb   = 1'b0;
                end else begin
                    blank_cnt = blank_cnt + 3'd1;
                    if (blank_cnt >= 3'(mced_pkg::SPACE_RUN)) begin
                        add_result(mced_pkg::CH_SPACE, 1'b0);
                        blank_cnt = '0;
                    end
                end
            end else begin
                // any other byte spoils the token and breaks a blank run
                tok_bad   = 1'b1;
                blank_cnt = '0;
            end
        end
        if (want_out.size() > base_cnt) want_out[want_out.size() - 1].last = 1'b1;
    endfunction

    // driver: one transfer at a time from the pending queue
    always @(posedge i_clk) begin : drive_bytes
        logic       next_push;
        logic [7:0] next_byte;
        logic       next_we;
        logic       next_wdata;
        next_push  = push;
        next_byte  = i_in_byte;
        next_we    = 1'b0;
        next_wdata = i_cfg_wdata;
        if (!i_rst_n) begin
            next_push  = 1'b0;
            gap_cnt    = 0;
            settle_cnt = 0;
            enc_mode   = 1'b1;
            prev_nb    = 1'b0;
            tok_bits   = '0;
            tok_len    = '0;
            tok_bad    = 1'b0;
            blank_cnt  = '0;
        end else begin
            if (push && !full) begin
                translate_byte(i_in_byte);
                next_push = 1'b0;
            end
            if (!next_push) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (in_bytes_q.size() > 0) begin
                    if (in_bytes_q[0].act == ACT_BYTE) begin
                        next_push = 1'b1;
                        next_byte = in_bytes_q[0].data;
                        calm_run  = in_bytes_q[0].calm;
                        // idle burst after this transfer
                        if (!in_bytes_q[0].calm && $urandom_range(0, 3) == 0) begin
                            gap_cnt = $urandom_range(1, 5);
                        end
                        void'(in_bytes_q.pop_front());
                    end else if (want_out.size() != 0) begin
                        settle_cnt = 0;
                    end else if (settle_cnt < SETTLE_CYCLES) begin
                        settle_cnt++;
                    end else begin
                        // block is idle: write the mode or just move on
                        if (in_bytes_q[0].act == ACT_MODE) begin
                            next_we    = 1'b1;
                            next_wdata = in_bytes_q[0].data[0];
                            enc_mode   = in_bytes_q[0].data[0];
                        end
                        settle_cnt = 0;
                        void'(in_bytes_q.pop_front());
                    end
                end
            end
        end
        push        <= next_push;
        i_in_byte   <= next_byte;
        i_cfg_we    <= next_we;
        i_cfg_wdata <= next_wdata;
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge i_clk) begin : check_results
        logic next_pop;
        t_out want;
        next_pop = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (want_out.size() == 0) begin
                    $error("result with nothing predicted: out_byte %0h is_error %0b last %0b",
                           o_out_byte, o_is_error, o_last);
                    error_count++;
                end else begin
                    want = want_out.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, o_out_byte);
                        error_count++;
                    end
                    if (o_is_error !== want.is_error) begin
                        $error("is_error: expected %0b, got %0b", want.is_error, o_is_error);
                        error_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_last);
                        error_count++;
                    end
                end
            end
            // receiver stalls at random while the current transfer is not calm
            if (hold_cnt > 0) begin
                hold_cnt--;
            end else if (!calm_run && $urandom_range(0, 5) == 0) begin
                hold_cnt = $urandom_range(0, 4);
            end else begin
                next_pop = 1'b1;
            end
        end
        pop <= next_pop;
    end

    task automatic queue_byte(input logic [7:0] b, input logic calm);
        t_stim e;
        e.act  = ACT_BYTE;
        e.data = b;
        e.calm = calm;
        in_bytes_q.push_back(e);
        queued_bytes++;
    endtask

    // ACT_MODE writes the register after the block drains, ACT_SETTLE only drains
    task automatic queue_wait(input t_act act, input logic v);
        t_stim e;
        e.act  = act;
        e.data = {7'd0, v};
        e.calm = 1'b0;
        in_bytes_q.push_back(e);
    endtask

    // text line material: mostly letters, digits and spaces
    task automatic gen_text(input int n, input logic calm);
        int stop;
        int r;
        stop = queued_bytes + n;
        while (queued_bytes < stop) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                queue_byte(glyph_of($urandom_range(0, 35)), calm);
            end else if (r < 70) begin
                queue_byte(mced_pkg::CH_SPACE, calm);
            end else if (r < 76) begin
                queue_byte(mced_pkg::CH_NL, calm);
            end else if (r < 84) begin
                queue_byte(8'($urandom_range(33, 126)), calm);   // printable, often unknown
            end else begin
                queue_byte(8'($urandom_range(0, 255)), calm);
            end
        end
    endtask

    // morse material: mostly valid tokens and blank runs, some broken tokens
    task automatic gen_morse(input int n, input logic calm);
        int    stop;
        int    r;
        int    cnt;
        string s;
        stop = queued_bytes + n;
        while (queued_bytes < stop) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                s = morse_of($urandom_range(0, 35));
                for (int k = 0; k < s.len(); k++) queue_byte(s[k], calm);
                if ($urandom_range(0, 9) == 0) begin
                    queue_byte(mced_pkg::CH_NL, calm);
                end else begin
                    queue_byte(mced_pkg::CH_SPACE, calm);
                    // word gap: seven blanks in a row
                    if ($urandom_range(0, 3) == 0) repeat (6) queue_byte(mced_pkg::CH_SPACE, calm);
                end
            end else if (r < 70) begin
                repeat ($urandom_range(1, 9)) queue_byte(mced_pkg::CH_SPACE, calm);
            end else if (r < 78) begin
                // random symbol string: unmapped patterns and overlong tokens
                cnt = $urandom_range(1, 8);
                repeat (cnt) begin
                    queue_byte($urandom_range(0, 1) ? mced_pkg::CH_DASH : mced_pkg::CH_DOT,
                               calm);
                end
                queue_byte(mced_pkg::CH_SPACE, calm);
            end else if (r < 86) begin
                queue_byte(8'($urandom_range(0, 255)), calm);
            end else if (r < 93) begin
                // token with a foreign byte inside
                repeat ($urandom_range(0, 2)) queue_byte(mced_pkg::CH_DOT, calm);
                queue_byte(8'($urandom_range(33, 255)), calm);
                repeat ($urandom_range(0, 2)) queue_byte(mced_pkg::CH_DASH, calm);
                queue_byte($urandom_range(0, 1) ? mced_pkg::CH_SPACE : mced_pkg::CH_NL, calm);
            end else begin
                queue_byte(mced_pkg::CH_NL, calm);
            end
        end
    endtask

    initial begin
        // directed encode: letter, digit, unknown after non-blank, space, newline
        queue_byte("A", 1'b0);
        queue_byte("Z", 1'b0);
        queue_byte("9", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(mced_pkg::CH_SPACE, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(mced_pkg::CH_NL, 1'b0);

        // directed decode: good token, overlong token at newline, lone bad byte,
        // then blanks completing a run of seven
        queue_wait(ACT_MODE, 1'b0);
        queue_byte(mced_pkg::CH_DOT, 1'b0);
        queue_byte(mced_pkg::CH_DASH, 1'b0);
        queue_byte(mced_pkg::CH_SPACE, 1'b0);
        repeat (6) queue_byte(mced_pkg::CH_DOT, 1'b0);
        queue_byte(mced_pkg::CH_NL, 1'b0);
        queue_byte("x", 1'b0);
        queue_byte(mced_pkg::CH_SPACE, 1'b0);
        repeat (6) queue_byte(mced_pkg::CH_SPACE, 1'b0);

        // random phases, the mode switching between them
        queue_wait(ACT_MODE, 1'b1);
        gen_text(60, 1'b0);
        queue_wait(ACT_MODE, 1'b0);
        gen_morse(35, 1'b0);
        queue_wait(ACT_SETTLE, 1'b0);      // sender holds off until all results are in
        gen_morse(35, 1'b0);
        queue_wait(ACT_MODE, 1'b1);
        gen_text(60, 1'b0);
        queue_wait(ACT_MODE, 1'b0);
        gen_morse(55, 1'b0);
        queue_wait(ACT_MODE, 1'b0);        // same value again, state kept
        gen_morse(20, 1'b0);
        queue_wait(ACT_MODE, 1'b1);
        gen_text(40, 1'b0);
        queue_wait(ACT_MODE, 1'b0);
        gen_morse(50, 1'b1);               // tail with no idling

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled away from the driving edge so pending updates have landed
        while (in_bytes_q.size() != 0 || push || want_out.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // hard limit on the run
    initial begin
        #2ms;
        $display("tb: done, errors");
        $finish;
    end

endmodule
